### sv/prrs_pkg.sv
// Shared types and constants of the priority round robin scheduler.
`timescale 1ns / 1ps

package prrs_pkg;

    localparam int OPCODE_W   = 1;
    localparam int SLOT_IN_W  = 4;
    localparam int ID_W       = 16;
    localparam int ARRIVAL_W  = 16;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int KIND_W     = 2;
    localparam int TIME_OUT_W = 20;
    localparam int SLICE_W    = 16;
    localparam int COUNT_W    = 5;
    localparam int QUANTUM_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ROT_W      = 32;

    localparam logic [OPCODE_W-1:0] OP_LOAD     = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DISPATCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_QUANTUM = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD     = 2'd0,
        KIND_SLICE    = 2'd1,
        KIND_IDLE     = 2'd2,
        KIND_ALL_DONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [ARRIVAL_W-1:0] arrival;
        logic [BURST_W-1:0]   burst;
        logic [BURST_W-1:0]   remaining;
        logic [PRIO_W-1:0]    prio;
    } t_task;

    typedef struct packed {
        t_kind                 kind;
        logic [SLOT_IN_W-1:0]  run_slot;
        logic [ID_W-1:0]       run_task_id;
        logic [TIME_OUT_W-1:0] start_time;
        logic [SLICE_W-1:0]    slice_length;
        logic                  finished;
        logic [TIME_OUT_W-1:0] completion_time;
        logic [TIME_OUT_W-1:0] turnaround;
        logic [TIME_OUT_W-1:0] waiting;
    } t_result;

endpackage

### sv/priority_round_robin_scheduler.sv
// Top level of the priority round robin scheduler: sequencer and state.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. A load writes one
// task slot and its result appears on the next cycle; busy stays low, so
// loads may be issued back to back. A dispatch that finds every task done
// also answers on the next cycle. Any other dispatch raises busy and runs a
// sequence: one pass over the used slots to find the best ready priority
// and its tie count, a bit-serial remainder of the rotation counter by that
// count, a second pass that picks the tied slot, and four update states.
// The length of a slice dispatch is set by the two passes over the single
// read port of the task memory and the 32 steps of the remainder unit; an
// idle tick ends after the first pass. Each result is shown for exactly one
// cycle with o_strobe high and the receiver cannot stall it. Configuration
// writes land at once through i_cfg_we. Reset clears time, the finished
// count, the rotation counter and the sequencer; the task memory is not
// cleared and must be loaded before use.
module priority_round_robin_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [prrs_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [prrs_pkg::SLOT_IN_W-1:0]      i_slot,
    input  logic [prrs_pkg::ID_W-1:0]           i_task_id,
    input  logic [prrs_pkg::ARRIVAL_W-1:0]      i_arrival,
    input  logic [prrs_pkg::BURST_W-1:0]        i_burst,
    input  logic [prrs_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic                                i_cfg_we,
    input  logic [prrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [prrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output logic [prrs_pkg::KIND_W-1:0]         o_kind,
    output logic [prrs_pkg::SLOT_IN_W-1:0]      o_run_slot,
    output logic [prrs_pkg::ID_W-1:0]           o_run_task_id,
    output logic [prrs_pkg::TIME_OUT_W-1:0]     o_start_time,
    output logic [prrs_pkg::SLICE_W-1:0]        o_slice_length,
    output logic                                o_finished,
    output logic [prrs_pkg::TIME_OUT_W-1:0]     o_completion_time,
    output logic [prrs_pkg::TIME_OUT_W-1:0]     o_turnaround,
    output logic [prrs_pkg::TIME_OUT_W-1:0]     o_waiting
);
    import prrs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN1    = 8'b0000_0010,
        S_MOD      = 8'b0000_0100,
        S_SCAN2    = 8'b0000_1000,
        S_SLICE    = 8'b0001_0000,
        S_ADVANCE  = 8'b0010_0000,
        S_COMPLETE = 8'b0100_0000,
        S_REPORT   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [COUNT_W-1:0]    r_task_count;
    logic [QUANTUM_W-1:0]  r_quantum;
    logic [TIME_BITS-1:0]  r_time;
    logic [COUNT_W-1:0]    r_fin_count;
    logic [ROT_W-1:0]      r_rot;
    logic [CNT_W-1:0]      r_scan_idx;
    logic                  r_chk_valid;
    logic [SLOT_W-1:0]     r_chk_idx;
    logic [PRIO_W:0]       r_best;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_pick;
    logic [CNT_W-1:0]      r_k;
    logic                  r_sel_found;
    logic [SLOT_W-1:0]     r_sel_idx;
    t_task                 r_sel;
    logic [SLICE_W-1:0]    r_ex;
    logic [TIME_BITS-1:0]  r_start;
    logic [TIME_BITS-1:0]  r_tat;
    logic                  r_strobe;
    t_result               r_res;
    t_result               n_res;
    logic                  n_strobe;

    logic                  w_accept;
    logic [CNT_W-1:0]      w_used;
    logic                  w_scan_end;
    logic                  w_ready;
    logic                  w_tied;
    logic                  w_mem_we;
    logic [SLOT_W-1:0]     w_mem_waddr;
    t_task                 w_mem_wdata;
    t_task                 w_rdata;
    logic                  w_mod_start;
    logic                  w_mod_done;
    logic [CNT_W-1:0]      w_mod_rem;
    logic [QUANTUM_W-1:0]  w_q;
    logic [TIME_BITS:0]    w_sum;
    logic [TIME_BITS-1:0]  w_wait;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        if (32'(r_task_count) > MAX_TASKS) begin
            w_used = CNT_W'(MAX_TASKS);
        end else begin
            w_used = CNT_W'(r_task_count);
        end
    end

    assign w_scan_end = (r_scan_idx == w_used) && !r_chk_valid;
    assign w_ready    = r_chk_valid && (TIME_BITS'(w_rdata.arrival) <= r_time)
                        && (w_rdata.remaining != '0);
    assign w_tied     = w_ready && ({1'b0, w_rdata.prio} == r_best);

    assign w_q   = (r_quantum == '0) ? QUANTUM_W'(1) : r_quantum;
    assign w_sum = {1'b0, r_time} + (TIME_BITS + 1)'(r_ex);
    assign w_wait = (r_tat >= TIME_BITS'(r_sel.burst)) ?
                    (r_tat - TIME_BITS'(r_sel.burst)) : '0;

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_sel_idx;
        w_mem_wdata = r_sel;
        if (w_accept && (i_opcode == OP_LOAD) && (32'(i_slot) < MAX_TASKS)) begin
            w_mem_we          = 1'b1;
            w_mem_waddr       = SLOT_W'(i_slot);
            w_mem_wdata.id        = i_task_id;
            w_mem_wdata.arrival   = i_arrival;
            w_mem_wdata.burst     = i_burst;
            w_mem_wdata.remaining = i_burst;
            w_mem_wdata.prio      = i_priority_req;
        end else if (r_state == S_ADVANCE) begin
            w_mem_we              = 1'b1;
            w_mem_wdata.remaining = r_sel.remaining - r_ex;
        end
    end

    prrs_task_ram #(
        .DEPTH  (MAX_TASKS),
        .ADDR_W (SLOT_W)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_scan_idx[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    prrs_rem_unit #(
        .DVD_W (ROT_W),
        .DSR_W (CNT_W)
    ) u_rem_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_mod_start),
        .i_dividend  (r_rot),
        .i_divisor   (r_cnt),
        .o_done      (w_mod_done),
        .o_remainder (w_mod_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_strobe    = 1'b0;
        n_res       = '0;
        w_mod_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_strobe = 1'b1;
                    if (i_opcode == OP_LOAD) begin
                        n_res.kind = KIND_LOAD;
                    end else if (r_fin_count >= r_task_count) begin
                        n_res.kind       = KIND_ALL_DONE;
                        n_res.start_time = TIME_OUT_W'(r_time);
                    end else begin
                        n_strobe = 1'b0;
                        n_state  = S_SCAN1;
                    end
                end
            end
            S_SCAN1: begin
                if (w_scan_end) begin
                    if (r_best[PRIO_W]) begin
                        n_strobe         = 1'b1;
                        n_res.kind       = KIND_IDLE;
                        n_res.start_time = TIME_OUT_W'(r_time);
                        n_state          = S_IDLE;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_SCAN2;
                end
            end
            S_SCAN2: begin
                if (w_scan_end) begin
                    n_state = S_SLICE;
                end
            end
            S_SLICE: begin
                n_state = S_ADVANCE;
            end
            S_ADVANCE: begin
                n_state = S_COMPLETE;
            end
            S_COMPLETE: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_strobe           = 1'b1;
                n_res.kind         = KIND_SLICE;
                n_res.run_slot     = SLOT_IN_W'(r_sel_idx);
                n_res.run_task_id  = r_sel.id;
                n_res.start_time   = TIME_OUT_W'(r_start);
                n_res.slice_length = r_ex;
                if (r_sel.remaining == '0) begin
                    n_res.finished        = 1'b1;
                    n_res.completion_time = TIME_OUT_W'(r_time);
                    n_res.turnaround      = TIME_OUT_W'(r_tat);
                    n_res.waiting         = TIME_OUT_W'(w_wait);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_task_count <= COUNT_W'(1);
            r_quantum    <= QUANTUM_W'(1);
            r_time       <= '0;
            r_fin_count  <= '0;
            r_rot        <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TASK_COUNT:   r_task_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_TIME_QUANTUM: r_quantum    <= i_cfg_data[QUANTUM_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_SCAN1) && w_scan_end && r_best[PRIO_W]
                    && (r_time != TIME_MAX)) begin
                r_time <= r_time + 1'b1;
            end
            if (r_state == S_MOD && w_mod_done) begin
                r_rot <= r_rot + 1'b1;
            end
            if (r_state == S_ADVANCE) begin
                r_time <= w_sum[TIME_BITS] ? TIME_MAX : w_sum[TIME_BITS-1:0];
            end
            if ((r_state == S_COMPLETE) && (r_sel.remaining == '0)
                    && (r_fin_count != '1)) begin
                r_fin_count <= r_fin_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == S_IDLE || (r_state == S_MOD && w_mod_done)) begin
            r_scan_idx  <= '0;
            r_chk_valid <= 1'b0;
            r_k         <= '0;
            r_sel_found <= 1'b0;
        end else if (r_state == S_SCAN1 || r_state == S_SCAN2) begin
            r_chk_idx <= r_scan_idx[SLOT_W-1:0];
            if (r_scan_idx < w_used) begin
                r_scan_idx  <= r_scan_idx + 1'b1;
                r_chk_valid <= 1'b1;
            end else begin
                r_chk_valid <= 1'b0;
            end
        end
        if (r_state == S_IDLE) begin
            r_best <= {1'b1, {PRIO_W{1'b0}}};
            r_cnt  <= '0;
        end else if (r_state == S_SCAN1 && w_ready) begin
            if ({1'b0, w_rdata.prio} < r_best) begin
                r_best <= {1'b0, w_rdata.prio};
                r_cnt  <= CNT_W'(1);
            end else if ({1'b0, w_rdata.prio} == r_best) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_state == S_MOD && w_mod_done) begin
            r_pick <= w_mod_rem;
        end
        if (r_state == S_SCAN2 && w_tied && !r_sel_found) begin
            if (r_k == r_pick) begin
                r_sel_found <= 1'b1;
                r_sel       <= w_rdata;
                r_sel_idx   <= r_chk_idx;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
        if (r_state == S_SLICE) begin
            r_ex <= (r_sel.remaining > w_q) ? w_q : r_sel.remaining;
        end
        if (r_state == S_ADVANCE) begin
            r_start         <= r_time;
            r_sel.remaining <= r_sel.remaining - r_ex;
        end
        if (r_state == S_COMPLETE) begin
            r_tat <= r_time - TIME_BITS'(r_sel.arrival);
        end
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_res.kind;
    assign o_run_slot        = r_res.run_slot;
    assign o_run_task_id     = r_res.run_task_id;
    assign o_start_time      = r_res.start_time;
    assign o_slice_length    = r_res.slice_length;
    assign o_finished        = r_res.finished;
    assign o_completion_time = r_res.completion_time;
    assign o_turnaround      = r_res.turnaround;
    assign o_waiting         = r_res.waiting;

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("Accepted command neither answered nor in progress.");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN2) |-> (r_pick < r_cnt))
        else $error("Rotation pick is not below the tie count.");

    a_slot_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLICE) |-> r_sel_found)
        else $error("Second pass ended without selecting a slot.");

    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("Current time moved backward.");

endmodule

### sv/prrs_task_ram.sv
// Task table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module prrs_task_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  prrs_pkg::t_task       i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output prrs_pkg::t_task       o_rdata
);
    import prrs_pkg::*;

    t_task r_mem [DEPTH];
    t_task r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/prrs_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module prrs_rem_unit #(
    parameter int DVD_W = 32,
    parameter int DSR_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DSR_W-1:0] o_remainder
);
    import prrs_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W-1:0]  r_rem;
    logic [DSR_W:0]    w_trial;
    logic [DSR_W:0]    w_diff;
    logic [DSR_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        if (w_trial >= {1'b0, r_dsr}) begin
            n_rem = w_diff[DSR_W-1:0];
        end else begin
            n_rem = w_trial[DSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule
